/* design/mmdpd_pkg.sv */
// Shared widths and register indexes for the matrix max dominant pair difference block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmdpd_pkg;

   localparam int ELEM_W     = 32;
   localparam int DIFF_W     = 33;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int CFG_W      = 7;
   localparam int CSR_ADDR_W = 1;

   localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_ROWS_IN_USE = 1'b0,
      REG_COLS_IN_USE = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

/* design/mmdpd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mmdpd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* design/matrix_max_dominant_pair_difference_top.sv */
// Top level of the matrix max dominant pair difference block.
// Uses mmdpd_pkg and the line-store RAM mmdpd_ram.
`timescale 1ns / 1ps
`default_nettype none

// Streams a matrix in row-major order, one signed 32-bit element per beat, and after
// the last element returns the largest m[d][e] - m[a][b] with d > a and e > b as an
// exact 33-bit value, or no_pair when the matrix has fewer than two rows or columns.
// Dimensions come from rows_in_use / cols_in_use (0 reads as 1, above MAX_DIM as
// MAX_DIM); a write drops any partial matrix. One element is taken every cycle unless a
// result waits on rsp_tready; the result passes stage 2 and the output register. The rate
// is set by the read-modify-write of the prefix-minimum line store (one RAM, one read
// and one write per cycle, last write forwarded); it needs no clearing after reset.
module matrix_max_dominant_pair_difference_top #(
   parameter int MAX_DIM = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [mmdpd_pkg::REQ_DATA_W-1:0]  req_tdata,   // [31:0] element
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [mmdpd_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [32:0] max_difference
   output logic                                   rsp_tuser,   // [0] no_pair
   input  wire logic                              csr_wen,
   input  wire logic [mmdpd_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [mmdpd_pkg::CFG_W-1:0]       csr_wdata
);

   import mmdpd_pkg::*;

   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int CNT_W = $clog2(MAX_DIM + 1);
   localparam int EXT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(v);
      if (ext == '0) begin
         ext = EXT_W'(1);
      end else if (ext > EXT_W'(MAX_DIM)) begin
         ext = EXT_W'(MAX_DIM);
      end
      return ext[CNT_W-1:0];
   endfunction

   // configuration
   logic [CFG_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [CNT_W-1:0] rows_eff, cols_eff;

   // position of next element
   logic [IDX_W-1:0] col_ff, col_in, row_ff, row_in;
   logic             col_last, row_last, accept;

   // stage 2
   logic                     s2_valid_ff, s2_valid_in;
   logic signed [ELEM_W-1:0] s2_elem_ff, s2_elem_in;
   logic [IDX_W-1:0]         s2_col_ff, s2_col_in;
   logic                     s2_first_ff, s2_first_in;
   logic                     s2_row0_ff, s2_row0_in;
   logic                     s2_last_ff, s2_last_in;
   logic                     s2_fire;

   logic signed [ELEM_W-1:0] left_ff, left_in, diag_ff, diag_in;
   logic signed [DIFF_W-1:0] best_ff, best_in;
   logic                     best_valid_ff, best_valid_in;

   // last line-store write, for forwarding
   logic                     fwd_valid_ff, fwd_valid_in;
   logic [IDX_W-1:0]         fwd_addr_ff, fwd_addr_in;
   logic signed [ELEM_W-1:0] fwd_data_ff, fwd_data_in;

   logic signed [ELEM_W-1:0] ram_rd, old_above, left_new, above_new;
   logic signed [DIFF_W-1:0] cand, best_val;
   logic                     best_take, best_vld;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DIFF_W-1:0] rsp_diff_ff, rsp_diff_in;
   logic                     rsp_nopair_ff, rsp_nopair_in;

   assign rows_eff = clamp_dim(rows_ff);
   assign cols_eff = clamp_dim(cols_ff);

   assign s2_fire    = s2_valid_ff && !(s2_last_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = !s2_valid_ff || s2_fire;
   assign accept     = req_tvalid && req_tready;

   assign col_last = (CNT_W'(col_ff) + CNT_W'(1)) >= cols_eff;
   assign row_last = (CNT_W'(row_ff) + CNT_W'(1)) >= rows_eff;

   mmdpd_ram #(
      .WIDTH(ELEM_W),
      .DEPTH(MAX_DIM)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (s2_fire),
      .wr_addr(s2_col_ff),
      .wr_data(above_new),
      .rd_en  (accept),
      .rd_addr(col_ff),
      .rd_data(ram_rd)
   );

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wen) begin
         case (csr_addr)
            REG_ROWS_IN_USE: rows_in = csr_wdata;
            REG_COLS_IN_USE: cols_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      s2_elem_in  = s2_elem_ff;
      s2_col_in   = s2_col_ff;
      s2_first_in = s2_first_ff;
      s2_row0_in  = s2_row0_ff;
      s2_last_in  = s2_last_ff;
      s2_valid_in = s2_fire ? 1'b0 : s2_valid_ff;
      if (accept) begin
         s2_valid_in = 1'b1;
         s2_elem_in  = req_tdata[ELEM_W-1:0];
         s2_col_in   = col_ff;
         s2_first_in = (col_ff == '0);
         s2_row0_in  = (row_ff == '0);
         s2_last_in  = col_last && row_last;
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + IDX_W'(1);
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
      if (csr_wen) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_comb begin
      old_above = (fwd_valid_ff && (fwd_addr_ff == s2_col_ff)) ? fwd_data_ff : ram_rd;
      left_new  = (s2_first_ff || (s2_elem_ff < left_ff)) ? s2_elem_ff : left_ff;
      above_new = (s2_row0_ff || (left_new < old_above)) ? left_new : old_above;
      cand      = DIFF_W'(s2_elem_ff) - DIFF_W'(diag_ff);
      best_take = !s2_row0_ff && !s2_first_ff && (!best_valid_ff || (cand > best_ff));
      best_val  = best_take ? cand : best_ff;
      best_vld  = best_take || best_valid_ff;

      left_in       = left_ff;
      diag_in       = diag_ff;
      best_in       = best_ff;
      best_valid_in = best_valid_ff;
      fwd_valid_in  = fwd_valid_ff;
      fwd_addr_in   = fwd_addr_ff;
      fwd_data_in   = fwd_data_ff;
      rsp_diff_in   = rsp_diff_ff;
      rsp_nopair_in = rsp_nopair_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      if (s2_fire) begin
         left_in      = left_new;
         diag_in      = old_above;
         best_in      = best_val;
         fwd_valid_in = 1'b1;
         fwd_addr_in  = s2_col_ff;
         fwd_data_in  = above_new;
         if (s2_last_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_diff_in   = best_vld ? best_val : '0;
            rsp_nopair_in = !best_vld;
            best_valid_in = 1'b0;
         end else begin
            best_valid_in = best_vld;
         end
      end
      if (csr_wen) begin
         best_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff       <= DIM_RESET;
         cols_ff       <= DIM_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         s2_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rows_ff       <= rows_in;
         cols_ff       <= cols_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         s2_valid_ff   <= s2_valid_in;
         best_valid_ff <= best_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_elem_ff    <= s2_elem_in;
      s2_col_ff     <= s2_col_in;
      s2_first_ff   <= s2_first_in;
      s2_row0_ff    <= s2_row0_in;
      s2_last_ff    <= s2_last_in;
      left_ff       <= left_in;
      diag_ff       <= diag_in;
      best_ff       <= best_in;
      fwd_addr_ff   <= fwd_addr_in;
      fwd_data_ff   <= fwd_data_in;
      rsp_diff_ff   <= rsp_diff_in;
      rsp_nopair_ff <= rsp_nopair_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(unsigned'(rsp_diff_ff));
   assign rsp_tuser  = rsp_nopair_ff;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s2_valid_ff && s2_last_ff && rsp_valid_ff))
      else $error("input stalled without a blocked result");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(s2_fire && s2_last_ff))
      else $error("result appeared without a last element");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(col_ff) < cols_eff) && (CNT_W'(row_ff) < rows_eff))
      else $error("position beyond matrix dimensions");

endmodule

`default_nettype wire
